[hw/rtl/safety_supervisor_fsm_defines.svh]
// assertion macros for the safety supervisor
// used by the top level; expects clk and rst in scope where expanded
`ifndef SAFETY_SUPERVISOR_FSM_DEFINES_SVH
`define SAFETY_SUPERVISOR_FSM_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ssf_pkg.sv]
// types and constants shared by the safety supervisor modules
// no dependencies
`default_nettype none

package ssf_pkg;

  localparam int NUM_TIMERS  = 4;
  localparam int LIMIT_W     = 24;
  localparam int TIME_W      = 32;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 3;

  // supervisor states
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_ARMED    = 3'd1;
  localparam logic [2:0] ST_RUNNING  = 3'd2;
  localparam logic [2:0] ST_HOLD     = 3'd3;
  localparam logic [2:0] ST_FAILSAFE = 3'd4;

  // timer slots
  localparam int T_HOLD    = 0;
  localparam int T_PLAN    = 1;
  localparam int T_LOC     = 2;
  localparam int T_MISSION = 3;

  // event codes
  localparam logic [2:0] EV_OVERRIDE  = 3'd0;
  localparam logic [2:0] EV_SENSOR_TO = 3'd1;
  localparam logic [2:0] EV_ESTOP     = 3'd2;
  localparam logic [2:0] EV_POSE_LOST = 3'd3;
  localparam logic [2:0] EV_STATIC    = 3'd4;
  localparam logic [2:0] EV_DYNAMIC   = 3'd5;
  localparam logic [2:0] EV_DEADMAN   = 3'd6;
  localparam logic [2:0] EV_PLAN_STALL = 3'd7;

  localparam logic SEV_WARNING  = 1'b0;
  localparam logic SEV_CRITICAL = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TO     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANNER_TO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOCALIZE_TO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MISSION_TO  = 3'd4;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [2:0]        hazard_flags;
    logic [1:0]        collision_kind;
    logic [4:0]        planner_flags;
    logic [1:0]        localization_flags;
    logic [2:0]        costmap_flags;
    logic              chassis_ok;
    logic              mode_change_active;
    logic [4:0]        request_flags;
    logic              mission_limit_on;
  } ssf_item_t;

  typedef struct packed {
    logic [2:0] safety_state;
    logic       drive_permit;
    logic       event_valid;
    logic [2:0] event_code;
    logic       event_severity;
  } ssf_result_t;

  // state update handed back to the top level
  typedef struct packed {
    logic [2:0]            mode;
    logic [NUM_TIMERS-1:0] active;
    logic [NUM_TIMERS-1:0] load;
  } ssf_update_t;

endpackage

`default_nettype wire

[hw/rtl/ssf_core.sv]
// decision logic of the safety supervisor: issues, timer expiry, state step, event
// depends on ssf_pkg
`default_nettype none

module ssf_core (
  input  ssf_pkg::ssf_item_t                                   item,
  input  logic                                                 enabled,
  input  logic [ssf_pkg::NUM_TIMERS-1:0][ssf_pkg::LIMIT_W-1:0] limits,
  input  logic [2:0]                                           mode_state,
  input  logic [ssf_pkg::NUM_TIMERS-1:0]                       timer_active,
  input  logic [ssf_pkg::NUM_TIMERS-1:0][ssf_pkg::TIME_W-1:0]  timer_start,
  output ssf_pkg::ssf_update_t                                 update,
  output ssf_pkg::ssf_result_t                                 result
);
  import ssf_pkg::*;

  logic force_fs, comm_ok, too_close;
  logic p_fail, p_path, p_fresh, p_glob, p_loc;
  logic l_deg, l_trust, c_req, c_val, c_fresh;
  logic start, arm, nav, motion, goal, armed_ok;
  logic plan_iss, loc_iss, cm_iss, hold_iss, fatal, mis_to;
  logic [NUM_TIMERS-1:0] cond, expired;
  logic [NUM_TIMERS-1:0][TIME_W-1:0] elapsed;
  logic [2:0] mode_next;
  logic [NUM_TIMERS-1:0] active_next;
  logic ev;
  logic [2:0] code;
  logic sev;

  always_comb begin
    force_fs  = item.hazard_flags[0];
    comm_ok   = item.hazard_flags[1];
    too_close = item.hazard_flags[2];
    p_fail    = item.planner_flags[0];
    p_path    = item.planner_flags[1];
    p_fresh   = item.planner_flags[2];
    p_glob    = item.planner_flags[3];
    p_loc     = item.planner_flags[4];
    l_deg     = item.localization_flags[0];
    l_trust   = item.localization_flags[1];
    c_req     = item.costmap_flags[0];
    c_val     = item.costmap_flags[1];
    c_fresh   = item.costmap_flags[2];
    start     = item.request_flags[0];
    arm       = item.request_flags[1];
    nav       = item.request_flags[2];
    motion    = item.request_flags[3];
    goal      = item.request_flags[4];
    armed_ok  = start & arm;

    plan_iss = p_fail | ~p_path | ~p_fresh | ~p_glob | ~p_loc;
    loc_iss  = l_deg | ~l_trust;
    cm_iss   = c_req & (~c_val | ~c_fresh);
    hold_iss = (item.collision_kind != 2'd0) | plan_iss | loc_iss | cm_iss
               | ~item.chassis_ok | item.mode_change_active;

    cond[T_HOLD]    = hold_iss;
    cond[T_PLAN]    = plan_iss;
    cond[T_LOC]     = loc_iss;
    cond[T_MISSION] = item.mission_limit_on & nav & ~goal;

    // a timer started by this word has zero elapsed time, so only a running one can expire
    for (int i = 0; i < NUM_TIMERS; i++) begin
      elapsed[i] = item.now_ms - timer_start[i];
      expired[i] = timer_active[i] & cond[i] & (limits[i] != '0)
                   & (elapsed[i] >= {{(TIME_W-LIMIT_W){1'b0}}, limits[i]});
    end
    mis_to = item.mission_limit_on & expired[T_MISSION];
    fatal  = force_fs | ~comm_ok | too_close | expired[T_LOC] | expired[T_PLAN]
             | expired[T_HOLD] | mis_to;

    mode_next   = mode_state;
    active_next = cond;
    if (fatal) begin
      mode_next = ST_FAILSAFE;
    end else begin
      unique case (mode_state)
        ST_IDLE: begin
          if (armed_ok && !loc_iss && !cm_iss && !item.mode_change_active)
            mode_next = ST_ARMED;
        end
        ST_ARMED: begin
          if (!armed_ok) mode_next = ST_IDLE;
          else if (nav && motion && !hold_iss) mode_next = ST_RUNNING;
        end
        ST_RUNNING: begin
          if (!armed_ok) mode_next = ST_IDLE;
          else if (hold_iss || !motion) mode_next = ST_HOLD;
        end
        ST_HOLD: begin
          if (!armed_ok) mode_next = ST_IDLE;
          else if (!hold_iss) mode_next = (nav && motion) ? ST_RUNNING : ST_ARMED;
        end
        ST_FAILSAFE: begin
          // recovery drops every timer
          if (!start && !nav) begin
            mode_next   = ST_IDLE;
            active_next = '0;
          end
        end
        default: mode_next = ST_FAILSAFE;
      endcase
    end

    ev   = 1'b1;
    code = EV_OVERRIDE;
    sev  = SEV_CRITICAL;
    priority if (!comm_ok) code = EV_SENSOR_TO;
    else if (too_close) code = EV_ESTOP;
    else if (mis_to) code = EV_OVERRIDE;
    else if (expired[T_LOC]) code = EV_POSE_LOST;
    else if (expired[T_PLAN] || expired[T_HOLD]) code = EV_OVERRIDE;
    else if (item.collision_kind == 2'd1) code = EV_STATIC;
    else if (item.collision_kind == 2'd2) code = EV_DYNAMIC;
    else if (!p_fresh) begin
      code = EV_DEADMAN;
      sev  = SEV_WARNING;
    end else if (l_deg) begin
      code = EV_POSE_LOST;
      sev  = SEV_WARNING;
    end else if (p_fail || !p_path) begin
      code = EV_PLAN_STALL;
      sev  = SEV_WARNING;
    end else if (cm_iss || !item.chassis_ok) begin
      code = EV_SENSOR_TO;
      sev  = SEV_WARNING;
    end else begin
      ev   = 1'b0;
      code = EV_OVERRIDE;
      sev  = SEV_WARNING;
    end

    if (!enabled) begin
      // policy not set up: failsafe with override, timers left as they are
      update.mode           = ST_FAILSAFE;
      update.active         = timer_active;
      update.load           = '0;
      result.safety_state   = ST_FAILSAFE;
      result.drive_permit   = 1'b0;
      result.event_valid    = 1'b1;
      result.event_code     = EV_OVERRIDE;
      result.event_severity = SEV_CRITICAL;
    end else begin
      update.mode           = mode_next;
      update.active         = active_next;
      update.load           = cond & ~timer_active;
      result.safety_state   = mode_next;
      result.drive_permit   = (mode_next == ST_RUNNING);
      result.event_valid    = ev;
      result.event_code     = code;
      result.event_severity = sev;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/safety_supervisor_fsm.sv]
// safety supervisor top level: channel registers, configuration and state storage
// depends on ssf_pkg, ssf_core and safety_supervisor_fsm_defines.svh
//
//   channel   direction   handshake          payload
//   s_*       in          tvalid / tready    tdata: one status snapshot
//   m_*       out         tvalid / tready    tdata: state, drive permit, event
//   cfg_*     in          valid / ready      cfg_index, cfg_data
//
// one word per clock sustained while the m side is not stalled; a result reaches m_tdata
// through the input register, then the decision logic into the result register
// rst is synchronous: state idle, timers unset, configuration 0, both channels empty
// a stalled m side holds the result and lets one more word into the input register
// cfg writes are always taken; an enabled write returns the machine to idle
`default_nettype none

module safety_supervisor_fsm (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [31:0] now_ms, [34:32] hazard_flags, [36:35] collision_kind,
  // [41:37] planner_flags, [43:42] localization_flags, [46:44] costmap_flags,
  // [47] chassis_ok, [48] mode_change_active, [53:49] request_flags,
  // [54] mission_limit_on, [55] zero
  input  logic [ssf_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [2:0] safety_state, [3] drive_permit, [4] event_valid,
  // [7:5] event_code, [8] event_severity, [15:9] zero
  output logic [ssf_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ssf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssf_pkg::LIMIT_W-1:0]       cfg_data
);
  import ssf_pkg::*;

  `include "safety_supervisor_fsm_defines.svh"

  logic                              enabled;
  logic [NUM_TIMERS-1:0][LIMIT_W-1:0] limits;
  logic [2:0]                        mode_state;
  logic [NUM_TIMERS-1:0]             timer_active;
  logic [NUM_TIMERS-1:0][TIME_W-1:0] timer_start;

  logic                  in_valid;
  logic [IN_TDATA_W-1:0] in_data;
  ssf_item_t             item;
  ssf_update_t           update;
  ssf_result_t           result;
  logic                  advance;
  logic                  cfg_fire;

  assign advance   = in_valid & (~m_tvalid | m_tready);
  assign s_tready  = ~in_valid | advance;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  always_comb begin
    item.now_ms             = in_data[31:0];
    item.hazard_flags       = in_data[34:32];
    item.collision_kind     = in_data[36:35];
    item.planner_flags      = in_data[41:37];
    item.localization_flags = in_data[43:42];
    item.costmap_flags      = in_data[46:44];
    item.chassis_ok         = in_data[47];
    item.mode_change_active = in_data[48];
    item.request_flags      = in_data[53:49];
    item.mission_limit_on   = in_data[54];
  end

  ssf_core u_core (
    .item         (item),
    .enabled      (enabled),
    .limits       (limits),
    .mode_state   (mode_state),
    .timer_active (timer_active),
    .timer_start  (timer_start),
    .update       (update),
    .result       (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      m_tdata <= {{(OUT_TDATA_W-9){1'b0}}, result.event_severity, result.event_code,
                  result.event_valid, result.drive_permit, result.safety_state};
    end
  end

  // configuration and supervisor state; an enabled write takes precedence
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled      <= 1'b0;
      limits       <= '0;
      mode_state   <= ST_IDLE;
      timer_active <= '0;
    end else begin
      if (cfg_fire && cfg_index == REG_ENABLED) begin
        enabled      <= cfg_data[0];
        mode_state   <= ST_IDLE;
        timer_active <= '0;
      end else if (advance) begin
        mode_state   <= update.mode;
        timer_active <= update.active;
      end
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_HOLD_TO:     limits[T_HOLD]    <= cfg_data;
          REG_PLANNER_TO:  limits[T_PLAN]    <= cfg_data;
          REG_LOCALIZE_TO: limits[T_LOC]     <= cfg_data;
          REG_MISSION_TO:  limits[T_MISSION] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // start stamps only mean something while their active bit is set
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (advance && update.load[i]) begin
        timer_start[i] <= item.now_ms;
      end
    end
  end

  `SSF_ASSERT_NEXT(a_enable_write_resets, cfg_fire && cfg_index == REG_ENABLED,
    mode_state == ST_IDLE && timer_active == '0, "enabled write did not reset state")
  `SSF_ASSERT_NEXT(a_disabled_override, advance && !enabled,
    m_tvalid && m_tdata[2:0] == ST_FAILSAFE && m_tdata[7:5] == EV_OVERRIDE && m_tdata[8],
    "disabled word did not give failsafe override")
  `SSF_ASSERT_NOW(a_motion_only_running, m_tvalid && m_tdata[3],
    m_tdata[2:0] == ST_RUNNING, "motion allowed outside running")
  `SSF_ASSERT_NOW(a_severity_needs_event, m_tvalid && m_tdata[8],
    m_tdata[4], "critical severity without event")
  `SSF_ASSERT_NEXT(a_failsafe_holds_motion, advance && result.safety_state == ST_FAILSAFE,
    mode_state == ST_FAILSAFE || mode_state == ST_IDLE, "failsafe result lost in state")

endmodule

`default_nettype wire

[tb/safety_supervisor_fsm_tb.sv]
// self-checking testbench for the safety supervisor: status snapshots in, state and event out
// keeps its own copy of the supervisor state and compares every result word field by field
// depends on ssf_pkg and the safety_supervisor_fsm top level
`timescale 1ns / 100ps

module safety_supervisor_fsm_tb;
  import ssf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;

  // a snapshot with nothing wrong in it
  localparam logic [2:0] HZ_OK  = 3'b010;
  localparam logic [4:0] PF_OK  = 5'b11110;
  localparam logic [1:0] LF_OK  = 2'b10;
  localparam logic [2:0] CF_OK  = 3'b111;
  localparam logic [4:0] RQ_ARM = 5'b00011;
  localparam logic [4:0] RQ_RUN = 5'b01111;
  localparam logic [4:0] RQ_OFF = 5'b00000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [LIMIT_W-1:0]     cfg_data = '0;

  safety_supervisor_fsm dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // supervisor copy: policy registers, mode and issue timers
  logic               pol_on;
  logic [LIMIT_W-1:0] lim_hold, lim_plan, lim_loc, lim_mission;
  logic [2:0]         sup_mode;
  logic [TIME_W-1:0]  issue_since [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] issue_live;

  ssf_item_t   pending_snaps [$];
  ssf_result_t due_results [$];
  ssf_item_t   on_bus;

  int          snaps_owed = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  bit          idling = 1'b0;
  bit          operator_on = 1'b1;
  logic [31:0] stamp = '0;
  int unsigned cycle_count = 0;
  int          n_bad = 0;
  int          n_snaps = 0;
  int          n_checked = 0;
  int          n_settings = 0;
  int          n_running = 0;
  int          n_failsafe = 0;
  int          n_events = 0;

  function automatic void clear_issues();
    for (int i = 0; i < NUM_TIMERS; i++) issue_since[i] = '0;
    issue_live = '0;
  endfunction

  function automatic void track_issue(int idx, logic present, logic [TIME_W-1:0] now);
    if (!present) begin
      issue_live[idx] = 1'b0;
      issue_since[idx] = '0;
    end else if (!issue_live[idx]) begin
      issue_live[idx] = 1'b1;
      issue_since[idx] = now;
    end
  endfunction

  // elapsed time wraps, so a stamp that goes backwards reads as very late
  function automatic logic issue_overdue(int idx, logic [TIME_W-1:0] now,
                                         logic [LIMIT_W-1:0] lim);
    logic [TIME_W-1:0] elapsed;
    elapsed = now - issue_since[idx];
    return issue_live[idx] && (lim != '0) && (elapsed >= {8'd0, lim});
  endfunction

  function automatic ssf_result_t supervise(ssf_item_t it);
    ssf_result_t r;
    logic comm_ok, too_close, nav, motion, operator_ok;
    logic plan_bad, loc_bad, cmap_bad, hold_bad;
    logic hold_late, plan_late, loc_late, mission_late, must_stop;
    r = '0;
    if (!pol_on) begin
      sup_mode = ST_FAILSAFE;
      r.safety_state   = ST_FAILSAFE;
      r.event_valid    = 1'b1;
      r.event_code     = EV_OVERRIDE;
      r.event_severity = SEV_CRITICAL;
      return r;
    end
    comm_ok   = it.hazard_flags[1];
    too_close = it.hazard_flags[2];
    nav       = it.request_flags[2];
    motion    = it.request_flags[3];
    plan_bad  = it.planner_flags[0] || !it.planner_flags[1] || !it.planner_flags[2] ||
                !it.planner_flags[3] || !it.planner_flags[4];
    loc_bad   = it.localization_flags[0] || !it.localization_flags[1];
    cmap_bad  = it.costmap_flags[0] && (!it.costmap_flags[1] || !it.costmap_flags[2]);
    // any collision kind, even the unnamed one, holds the vehicle
    hold_bad  = (it.collision_kind != 2'd0) || plan_bad || loc_bad || cmap_bad ||
                !it.chassis_ok || it.mode_change_active;

    track_issue(T_HOLD, hold_bad, it.now_ms);
    track_issue(T_PLAN, plan_bad, it.now_ms);
    track_issue(T_LOC, loc_bad, it.now_ms);
    track_issue(T_MISSION, it.mission_limit_on && nav && !it.request_flags[4], it.now_ms);

    hold_late    = issue_overdue(T_HOLD, it.now_ms, lim_hold);
    plan_late    = issue_overdue(T_PLAN, it.now_ms, lim_plan);
    loc_late     = issue_overdue(T_LOC, it.now_ms, lim_loc);
    mission_late = it.mission_limit_on && issue_overdue(T_MISSION, it.now_ms, lim_mission);
    must_stop    = it.hazard_flags[0] || !comm_ok || too_close || loc_late || plan_late ||
                   hold_late || mission_late;
    operator_ok  = it.request_flags[0] && it.request_flags[1];

    if (must_stop) begin
      sup_mode = ST_FAILSAFE;
    end else begin
      case (sup_mode)
        ST_IDLE: begin
          if (operator_ok && !loc_bad && !cmap_bad && !it.mode_change_active)
            sup_mode = ST_ARMED;
        end
        ST_ARMED: begin
          if (!operator_ok) sup_mode = ST_IDLE;
          else if (nav && motion && !hold_bad) sup_mode = ST_RUNNING;
        end
        ST_RUNNING: begin
          if (!operator_ok) sup_mode = ST_IDLE;
          else if (hold_bad || !motion) sup_mode = ST_HOLD;
        end
        ST_HOLD: begin
          if (!operator_ok) sup_mode = ST_IDLE;
          else if (!hold_bad) sup_mode = (nav && motion) ? ST_RUNNING : ST_ARMED;
        end
        ST_FAILSAFE: begin
          // leaving failsafe needs start and navigation both dropped
          if (!it.request_flags[0] && !nav) begin
            sup_mode = ST_IDLE;
            clear_issues();
          end
        end
        default: sup_mode = ST_FAILSAFE;
      endcase
    end

    r.safety_state   = sup_mode;
    r.drive_permit   = (sup_mode == ST_RUNNING);
    r.event_valid    = 1'b1;
    r.event_severity = SEV_CRITICAL;
    if (!comm_ok) r.event_code = EV_SENSOR_TO;
    else if (too_close) r.event_code = EV_ESTOP;
    else if (mission_late) r.event_code = EV_OVERRIDE;
    else if (loc_late) r.event_code = EV_POSE_LOST;
    else if (plan_late || hold_late) r.event_code = EV_OVERRIDE;
    else if (it.collision_kind == 2'd1) r.event_code = EV_STATIC;
    else if (it.collision_kind == 2'd2) r.event_code = EV_DYNAMIC;
    else begin
      r.event_severity = SEV_WARNING;
      if (!it.planner_flags[2]) r.event_code = EV_DEADMAN;
      else if (it.localization_flags[0]) r.event_code = EV_POSE_LOST;
      else if (it.planner_flags[0] || !it.planner_flags[1]) r.event_code = EV_PLAN_STALL;
      else if (cmap_bad || !it.chassis_ok) r.event_code = EV_SENSOR_TO;
      else r.event_valid = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_snapshot(ssf_item_t it);
    return {1'b0, it.mission_limit_on, it.request_flags, it.mode_change_active,
            it.chassis_ok, it.costmap_flags, it.localization_flags, it.planner_flags,
            it.collision_kind, it.hazard_flags, it.now_ms};
  endfunction

  function automatic ssf_item_t mk_snap(logic [31:0] now, logic [2:0] hz, logic [1:0] coll,
                                        logic [4:0] pf, logic [1:0] lf, logic [2:0] cf,
                                        logic ch, logic mc, logic [4:0] rq, logic mis);
    ssf_item_t it;
    it.now_ms = now;
    it.hazard_flags = hz;
    it.collision_kind = coll;
    it.planner_flags = pf;
    it.localization_flags = lf;
    it.costmap_flags = cf;
    it.chassis_ok = ch;
    it.mode_change_active = mc;
    it.request_flags = rq;
    it.mission_limit_on = mis;
    return it;
  endfunction

  // mostly healthy snapshots from an operator who arms and drives, with faults sprinkled in
  function automatic ssf_item_t gen_snapshot();
    ssf_item_t   it;
    logic [63:0] raw;
    int          dice;
    dice = $urandom_range(0, 99);
    if (dice < 3) stamp = $urandom();
    else if (dice < 6) stamp = stamp - $urandom_range(1, 40);
    else stamp = stamp + $urandom_range(0, 6);
    if ($urandom_range(0, 99) < 3) operator_on = !operator_on;
    if ($urandom_range(0, 99) < 12) begin
      raw = {$urandom(), $urandom()};
      it = raw[$bits(ssf_item_t)-1:0];
      it.now_ms = stamp;
      return it;
    end
    it.now_ms = stamp;
    it.hazard_flags = ($urandom_range(0, 99) < 4) ? 3'($urandom_range(0, 7)) : HZ_OK;
    it.collision_kind = ($urandom_range(0, 99) < 8) ? 2'($urandom_range(0, 3)) : 2'd0;
    it.planner_flags = ($urandom_range(0, 99) < 10) ? 5'($urandom_range(0, 31)) : PF_OK;
    it.localization_flags = ($urandom_range(0, 99) < 8) ? 2'($urandom_range(0, 3)) : LF_OK;
    if ($urandom_range(0, 99) < 10) it.costmap_flags = 3'($urandom_range(0, 7));
    else it.costmap_flags = $urandom_range(0, 1) ? CF_OK : 3'b110;
    it.chassis_ok = ($urandom_range(0, 99) >= 5);
    it.mode_change_active = ($urandom_range(0, 99) < 4);
    if (operator_on) begin
      it.request_flags[0] = ($urandom_range(0, 99) >= 3);
      it.request_flags[1] = ($urandom_range(0, 99) >= 5);
      it.request_flags[2] = ($urandom_range(0, 99) >= 15);
      it.request_flags[3] = ($urandom_range(0, 99) >= 15);
      it.request_flags[4] = ($urandom_range(0, 99) < 8);
    end else begin
      it.request_flags = 5'($urandom_range(0, 31)) & 5'b11010;
    end
    it.mission_limit_on = ($urandom_range(0, 99) < 60);
    return it;
  endfunction

  function automatic int pick_pause();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_bad++;
    end
  endfunction

  task automatic queue_snap(ssf_item_t it);
    pending_snaps.push_back(it);
    snaps_owed++;
  endtask

  // wait for every owed result, then for the pipeline to drain
  task automatic settle();
    while (snaps_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ENABLED: begin
        pol_on = val[0];
        sup_mode = ST_IDLE;
        clear_issues();
      end
      REG_HOLD_TO:     lim_hold = val;
      REG_PLANNER_TO:  lim_plan = val;
      REG_LOCALIZE_TO: lim_loc = val;
      REG_MISSION_TO:  lim_mission = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic en, logic [LIMIT_W-1:0] h, logic [LIMIT_W-1:0] p,
                           logic [LIMIT_W-1:0] l, logic [LIMIT_W-1:0] m, bit busy);
    settle();
    idling = busy;
    write_reg(REG_HOLD_TO, h);
    write_reg(REG_PLANNER_TO, p);
    write_reg(REG_LOCALIZE_TO, l);
    write_reg(REG_MISSION_TO, m);
    // upper bits of the enable word are don't-care
    write_reg(REG_ENABLED, {23'($urandom()), en});
    n_settings++;
  endtask

  // snapshot driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        due_results.push_back(supervise(on_bus));
        n_snaps++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_snaps.size() != 0) begin
          on_bus = pending_snaps.pop_front();
          s_tdata <= pack_snapshot(on_bus);
          s_tvalid <= 1'b1;
          if (idling && $urandom_range(0, 3) == 0) gap_left = pick_pause();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and back-pressure
  always @(posedge clk) begin
    ssf_result_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.safety_state   = m_tdata[2:0];
        got.drive_permit   = m_tdata[3];
        got.event_valid    = m_tdata[4];
        got.event_code     = m_tdata[7:5];
        got.event_severity = m_tdata[8];
        if (due_results.size() == 0) begin
          $error("result word with no snapshot outstanding: %h", m_tdata);
          n_bad++;
        end else begin
          want = due_results.pop_front();
          check_field("safety_state", want.safety_state, got.safety_state);
          check_field("drive_permit", want.drive_permit, got.drive_permit);
          check_field("event_valid", want.event_valid, got.event_valid);
          check_field("event_code", want.event_code, got.event_code);
          check_field("event_severity", want.event_severity, got.event_severity);
          n_checked++;
          snaps_owed--;
          if (want.safety_state == ST_RUNNING) n_running++;
          if (want.safety_state == ST_FAILSAFE) n_failsafe++;
          if (want.event_valid) n_events++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall_left = pick_pause() - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL safety_supervisor_fsm");
      $finish;
    end
  end

  initial begin
    pol_on = 1'b0;
    lim_hold = '0;
    lim_plan = '0;
    lim_loc = '0;
    lim_mission = '0;
    sup_mode = ST_IDLE;
    clear_issues();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // policy off: every word is an override into failsafe
    configure(1'b0, '0, '0, '0, '0, 1'b1);
    queue_snap(mk_snap(32'h0, 3'b000, 2'd0, 5'b00000, 2'b00, 3'b000, 1'b0, 1'b0, RQ_OFF, 1'b0));
    queue_snap(mk_snap(32'hFFFF_FFFF, 3'b111, 2'd3, 5'b11111, 2'b11, 3'b111, 1'b1, 1'b1,
                       5'b11111, 1'b1));

    // walk through the machine, every event code and the timeouts
    configure(1'b1, 24'd10, 24'd20, 24'd15, 24'd40, 1'b1);
    queue_snap(mk_snap(32'd100, HZ_OK, 2'd0, PF_OK, LF_OK, CF_OK, 1'b1, 1'b0, RQ_ARM, 1'b1));
    queue_snap(mk_snap(32'd101, HZ_OK, 2'd0, PF_OK, LF_OK, CF_OK, 1'b1, 1'b0, RQ_RUN, 1'b0));
    queue_snap(mk_snap(32'd102, HZ_OK, 2'd1, PF_OK, LF_OK, CF_OK, 1'b1, 1'b0, RQ_RUN, 1'b0));
    queue_snap(mk_snap(32'd103, HZ_OK, 2'd2, PF_OK, LF_OK, CF_OK, 1'b1, 1'b0, RQ_RUN, 1'b0));
    // unnamed collision kind holds but reports nothing
    queue_snap(mk_snap(32'd104, HZ_OK, 2'd3, PF_OK, LF_OK, CF_OK, 1'b1, 1'b0, RQ_RUN, 1'b0));
    queue_snap(mk_snap(32'd105, HZ_OK, 2'd0, PF_OK, LF_OK, CF_OK, 1'b1, 1'b0, RQ_RUN, 1'b0));
    queue_snap(mk_snap(32'd106, HZ_OK, 2'd0, 5'b11010, LF_OK, CF_OK, 1'b1, 1'b0, RQ_RUN, 1'b0));
    queue_snap(mk_snap(32'd107, HZ_OK, 2'd0, PF_OK, 2'b11, CF_OK, 1'b1, 1'b0, RQ_RUN, 1'b0));
    queue_snap(mk_snap(32'd108, HZ_OK, 2'd0, 5'b11111, LF_OK, CF_OK, 1'b1, 1'b0, RQ_RUN, 1'b0));
    queue_snap(mk_snap(32'd109, HZ_OK, 2'd0, PF_OK, LF_OK, 3'b011, 1'b0, 1'b0, RQ_RUN, 1'b0));
    queue_snap(mk_snap(32'd117, HZ_OK, 2'd0, PF_OK, LF_OK, CF_OK, 1'b1, 1'b1, RQ_RUN, 1'b0));
    queue_snap(mk_snap(32'd118, HZ_OK, 2'd0, PF_OK, LF_OK, CF_OK, 1'b1, 1'b0, RQ_OFF, 1'b0));
    queue_snap(mk_snap(32'd119, 3'b000, 2'd0, PF_OK, LF_OK, CF_OK, 1'b1, 1'b0, RQ_OFF, 1'b0));
    queue_snap(mk_snap(32'd120, 3'b110, 2'd0, PF_OK, LF_OK, CF_OK, 1'b1, 1'b0, RQ_OFF, 1'b0));
    queue_snap(mk_snap(32'd121, 3'b011, 2'd0, PF_OK, LF_OK, CF_OK, 1'b1, 1'b0, RQ_OFF, 1'b0));
    queue_snap(mk_snap(32'd122, HZ_OK, 2'd0, PF_OK, LF_OK, CF_OK, 1'b1, 1'b0, RQ_OFF, 1'b0));
    queue_snap(mk_snap(32'd130, HZ_OK, 2'd0, PF_OK, 2'b00, CF_OK, 1'b1, 1'b0, RQ_ARM, 1'b0));
    queue_snap(mk_snap(32'd146, HZ_OK, 2'd0, PF_OK, 2'b00, CF_OK, 1'b1, 1'b0, RQ_ARM, 1'b0));
    queue_snap(mk_snap(32'd200, HZ_OK, 2'd0, PF_OK, LF_OK, CF_OK, 1'b1, 1'b0, RQ_OFF, 1'b1));
    queue_snap(mk_snap(32'd201, HZ_OK, 2'd0, PF_OK, LF_OK, CF_OK, 1'b1, 1'b0, RQ_RUN, 1'b1));
    queue_snap(mk_snap(32'd202, HZ_OK, 2'd0, PF_OK, LF_OK, CF_OK, 1'b1, 1'b0, RQ_RUN, 1'b1));
    queue_snap(mk_snap(32'd242, HZ_OK, 2'd0, PF_OK, LF_OK, CF_OK, 1'b1, 1'b0, RQ_RUN, 1'b1));
    queue_snap(mk_snap(32'd243, HZ_OK, 2'd0, PF_OK, LF_OK, CF_OK, 1'b1, 1'b0, RQ_OFF, 1'b0));
    // loc issue across the wrap, then a stamp that steps backwards
    queue_snap(mk_snap(32'hFFFF_FFFE, HZ_OK, 2'd0, PF_OK, 2'b00, CF_OK, 1'b1, 1'b0, RQ_ARM,
                       1'b0));
    queue_snap(mk_snap(32'd3, HZ_OK, 2'd0, PF_OK, 2'b00, CF_OK, 1'b1, 1'b0, RQ_ARM, 1'b0));
    queue_snap(mk_snap(32'd1, HZ_OK, 2'd0, PF_OK, 2'b00, CF_OK, 1'b1, 1'b0, RQ_ARM, 1'b0));

    // random operation under a spread of limits
    stamp = 32'd1000;
    configure(1'b1, 24'd10, 24'd25, 24'd15, 24'd60, 1'b0);
    repeat (250) queue_snap(gen_snapshot());
    configure(1'b1, '0, '0, '0, '0, 1'b1);
    repeat (200) queue_snap(gen_snapshot());
    stamp = 32'hFFFF_FF00;
    configure(1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    repeat (200) queue_snap(gen_snapshot());
    configure(1'b1, 24'd1, 24'd1, 24'd1, 24'd1, 1'b1);
    repeat (200) queue_snap(gen_snapshot());
    configure(1'b0, 24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()), 1'b1);
    repeat (40) queue_snap(gen_snapshot());
    stamp = $urandom();
    configure(1'b1, 24'($urandom_range(1, 64)), 24'($urandom_range(1, 64)),
              24'($urandom_range(1, 64)), 24'($urandom_range(1, 64)), 1'b1);
    repeat (250) queue_snap(gen_snapshot());
    configure(1'b1, 24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()), 1'b0);
    repeat (150) queue_snap(gen_snapshot());
    configure(1'b1, 24'($urandom_range(2, 30)), 24'($urandom_range(2, 30)),
              24'($urandom_range(2, 30)), 24'($urandom_range(2, 30)), 1'b1);
    repeat (360) queue_snap(gen_snapshot());

    settle();
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      n_bad++;
    end
    $display("covered %0d snapshots under %0d register settings, %0d result words checked",
             n_snaps, n_settings, n_checked);
    $display("results: %0d running, %0d failsafe, %0d carrying an event",
             n_running, n_failsafe, n_events);
    if (n_bad == 0) begin
      $display("PASS safety_supervisor_fsm");
    end else begin
      $display("FAIL safety_supervisor_fsm");
    end
    $finish;
  end

endmodule
